@@ sv/rms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg
// Types and constants shared by the run-length vector sum block.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int LENGTH_BITS = 31;
    localparam int SUM_BITS    = 35;
    localparam int CFG_BITS    = 4;

    localparam logic [CFG_BITS-1:0] LIST_COUNT_RESET = 4'd8;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PULL  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]                    action;
        logic [2:0]                    list_index;
        logic signed [VALUE_BITS-1:0]  run_value;
        logic [LENGTH_BITS-1:0]        run_length;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]    run_sum;
        logic [LENGTH_BITS-1:0]        merged_length;
        logic                          final_run;
        logic                          no_run;
        logic                          overflow;
    } out_word_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  value;
        logic [LENGTH_BITS-1:0]        length;
    } run_entry_t;

endpackage

@@ sv/rms_run_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_run_mem
// Run store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rms_run_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  rms_pkg::run_entry_t     wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output rms_pkg::run_entry_t     rdata
);
    import rms_pkg::*;

    run_entry_t mem [DEPTH];
    run_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rle_multi_stream_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_multi_stream_sum
// Position-wise sum of run-length encoded lists, emitted as merged runs.
// ----------------------------------------------------------------------------
// Channel   Signals                         Carries
// in        in_valid, in_ready, in_word     load, pull or clear word
// out       out_valid, out_ready, out_word  one merged run or empty result per pull
// cfg       cfg_we, cfg_wdata               number of active lists
//
// Load and clear finish in the cycle they are accepted.
// A pull walks one segment at a time over the N active lists: a scan over the
// run memory read port, a drain and decide step, and an update pass.
// Reset needs no clearing pass; the run memory is only read below fill counts.
// A pull waits only when its result meets a full output register.
// ----------------------------------------------------------------------------
module rle_multi_stream_sum #(
    parameter int LISTS         = 8,
    parameter int RUNS_PER_LIST = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rms_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rms_pkg::out_word_t  out_word,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);
    import rms_pkg::*;

    localparam int LW    = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int CW    = $clog2(LISTS + 1);
    localparam int PW    = $clog2(RUNS_PER_LIST + 1);
    localparam int DEPTH = LISTS * RUNS_PER_LIST;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]     list_count_reg;
    logic [PW-1:0]           rl_reg  [LISTS];
    logic [PW-1:0]           rp_reg  [LISTS];
    logic [LENGTH_BITS-1:0]  off_reg [LISTS];
    logic [LENGTH_BITS-1:0]  avail_reg [LISTS];

    logic [CW-1:0]           i_reg, i_next;
    logic signed [SUM_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]  min_reg, min_next;
    logic                    any_reg, any_next;
    logic                    rd_v_reg, rd_v_next;
    logic [LW-1:0]           rd_list_reg, rd_list_next;
    logic [LENGTH_BITS-1:0]  off_q_reg, off_q_next;
    logic                    done_reg, done_next;

    logic signed [SUM_BITS-1:0] psum_reg, psum_next;
    logic [LENGTH_BITS-1:0]  plen_reg, plen_next;
    logic                    pv_reg, pv_next;
    logic                    ovf_reg, ovf_next;

    out_word_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [CW-1:0]           n_eff;
    logic [LW-1:0]           idx;
    logic                    ent_active;
    logic                    ent_we;
    logic [PW-1:0]           ent_rl_next, ent_rp_next;
    logic [LENGTH_BITS-1:0]  ent_off_next;
    logic                    clear_all;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    run_entry_t              mem_wdata, mem_rdata;

    logic                    accept, slot_free, load_ok;
    logic [LENGTH_BITS-1:0]  avail;
    logic [LENGTH_BITS:0]    plen_sum;

    rms_run_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        if (list_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(list_count_reg) > LISTS)
        begin
            n_eff = CW'(LISTS);
        end
        else
        begin
            n_eff = CW'(list_count_reg);
        end
    end

    assign idx        = (state_reg == ST_IDLE) ? LW'(in_word.list_index) : i_reg[LW-1:0];
    assign ent_active = rp_reg[idx] < rl_reg[idx];
    assign avail      = mem_rdata.length - off_q_reg;
    assign plen_sum   = {1'b0, plen_reg} + {1'b0, min_reg};
    assign load_ok    = (32'(in_word.list_index) < LISTS) && (in_word.run_length != '0);

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        min_next       = min_reg;
        any_next       = any_reg;
        rd_v_next      = 1'b0;
        rd_list_next   = rd_list_reg;
        off_q_next     = off_q_reg;
        done_next      = done_reg;
        psum_next      = psum_reg;
        plen_next      = plen_reg;
        pv_next        = pv_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ent_we         = 1'b0;
        ent_rl_next    = rl_reg[idx];
        ent_rp_next    = rp_reg[idx];
        ent_off_next   = off_reg[idx];
        clear_all      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = AW'(idx) * AW'(RUNS_PER_LIST) + AW'(rl_reg[idx]);
        mem_raddr      = AW'(idx) * AW'(RUNS_PER_LIST) + AW'(rp_reg[idx]);
        mem_wdata      = '{value: in_word.run_value, length: in_word.run_length};

        if (rd_v_reg)
        begin
            acc_next = acc_reg + SUM_BITS'(mem_rdata.value);
            any_next = 1'b1;
            if (avail < min_reg)
            begin
                min_next = avail;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_word.action)
                        ACT_LOAD:
                        begin
                            if (load_ok && (rl_reg[idx] >= PW'(RUNS_PER_LIST)))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (load_ok)
                            begin
                                mem_we      = 1'b1;
                                ent_we      = 1'b1;
                                ent_rl_next = rl_reg[idx] + PW'(1);
                            end
                        end
                        ACT_PULL:
                        begin
                            i_next     = '0;
                            acc_next   = '0;
                            min_next   = LENGTH_MAX;
                            any_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            clear_all = 1'b1;
                            psum_next = '0;
                            plen_next = '0;
                            pv_next   = 1'b0;
                            ovf_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (i_reg < n_eff)
                begin
                    mem_re       = ent_active;
                    rd_v_next    = ent_active;
                    rd_list_next = idx;
                    off_q_next   = off_reg[idx];
                    i_next       = i_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                i_next = '0;
                if (!any_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next.overflow = ovf_reg;
                        if (pv_reg)
                        begin
                            out_next.run_sum       = psum_reg;
                            out_next.merged_length = plen_reg;
                            out_next.final_run     = 1'b1;
                            out_next.no_run        = 1'b0;
                            pv_next   = 1'b0;
                            psum_next = '0;
                            plen_next = '0;
                        end
                        else
                        begin
                            out_next.run_sum       = '0;
                            out_next.merged_length = '0;
                            out_next.final_run     = 1'b0;
                            out_next.no_run        = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (pv_reg && (psum_reg == acc_reg))
                begin
                    plen_next  = plen_sum[LENGTH_BITS] ? LENGTH_MAX
                                                       : plen_sum[LENGTH_BITS-1:0];
                    done_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
                else if (pv_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next         = 1'b1;
                        out_next.run_sum       = psum_reg;
                        out_next.merged_length = plen_reg;
                        out_next.final_run     = 1'b0;
                        out_next.no_run        = 1'b0;
                        out_next.overflow      = ovf_reg;
                        psum_next  = acc_reg;
                        plen_next  = min_reg;
                        done_next  = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
                else
                begin
                    pv_next    = 1'b1;
                    psum_next  = acc_reg;
                    plen_next  = min_reg;
                    done_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (i_reg < n_eff)
                begin
                    if (ent_active)
                    begin
                        ent_we = 1'b1;
                        if (avail_reg[idx] == min_reg)
                        begin
                            ent_rp_next  = rp_reg[idx] + PW'(1);
                            ent_off_next = '0;
                        end
                        else
                        begin
                            ent_off_next = off_reg[idx] + min_reg;
                        end
                    end
                    i_next = i_reg + CW'(1);
                end
                else if (done_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    min_next   = LENGTH_MAX;
                    any_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            list_count_reg <= LIST_COUNT_RESET;
            i_reg          <= '0;
            any_reg        <= 1'b0;
            rd_v_reg       <= 1'b0;
            done_reg       <= 1'b0;
            psum_reg       <= '0;
            plen_reg       <= '0;
            pv_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            any_reg       <= any_next;
            rd_v_reg      <= rd_v_next;
            done_reg      <= done_next;
            psum_reg      <= psum_next;
            plen_reg      <= plen_next;
            pv_reg        <= pv_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                list_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LISTS; k++)
            begin
                rl_reg[k]  <= '0;
                rp_reg[k]  <= '0;
                off_reg[k] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int k = 0; k < LISTS; k++)
            begin
                rl_reg[k]  <= '0;
                rp_reg[k]  <= '0;
                off_reg[k] <= '0;
            end
        end
        else if (ent_we)
        begin
            rl_reg[idx]  <= ent_rl_next;
            rp_reg[idx]  <= ent_rp_next;
            off_reg[idx] <= ent_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        min_reg     <= min_next;
        rd_list_reg <= rd_list_next;
        off_q_reg   <= off_q_next;
        out_reg     <= out_next;
        if (rd_v_reg)
        begin
            avail_reg[rd_list_reg] <= avail;
        end
    end

endmodule

@@ sv/rms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks on the result channel of the run-length vector sum block.
// ----------------------------------------------------------------------------
module rms_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rms_pkg::out_word_t  out_word
);
    import rms_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("Result word changed while stalled.");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.final_run && out_word.no_run))
        else $error("A word is both the final run and an empty result.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.no_run |->
            out_word.run_sum == '0 && out_word.merged_length == '0)
        else $error("An empty result carries data.");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.no_run |-> out_word.merged_length != '0)
        else $error("A merged run has zero length.");

endmodule

bind rle_multi_stream_sum rms_checker u_rms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
